@@ hw/rtl/gitc_pkg.sv @@
// Shared constants, codes and types of the grid isoline triangle crossings core.
// Depends on nothing; gitc_edge, the core and the bench import it.
`default_nettype none
package gitc_pkg;
   localparam int MAX_COLUMNS   = 1024;
   localparam int MAX_ROWS      = 1024;
   localparam int SAMPLE_BITS   = 32;
   localparam int FRACTION_BITS = 16;
   localparam int EPS_BITS      = 16;
   localparam int COL_BITS      = 10;
   localparam int CNT_BITS      = 11;
   localparam int COORD_BITS    = 26;

   // register indexes (byte address / 4)
   localparam logic [2:0] REG_LEVEL   = 3'd0;
   localparam logic [2:0] REG_TOL     = 3'd1;
   localparam logic [2:0] REG_KEEP    = 3'd2;
   localparam logic [2:0] REG_COLUMNS = 3'd3;
   localparam logic [2:0] REG_ROWS    = 3'd4;

   typedef enum logic [2:0] {
      E_IDLE, E_PREP, E_MUL, E_CMP, E_DIV, E_ROUND, E_OUT
   } edge_state_type;

   typedef enum logic [2:0] {
      T_IDLE, T_READ, T_START, T_WAIT, T_FLUSH
   } top_state_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] pz;
      logic signed [SAMPLE_BITS-1:0] qz;
      logic [COL_BITS-1:0] px;
      logic [COL_BITS-1:0] py;
      logic [COL_BITS-1:0] qx;
      logic [COL_BITS-1:0] qy;
   } edge_req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] level;
      logic [EPS_BITS-1:0]           tol;
      logic                          keep;
      logic [CNT_BITS-1:0]           rows;
   } edge_cfg_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
   } point_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic                  tri_b;
      logic                  first;
   } result_type;

   function automatic logic [SAMPLE_BITS-1:0] mag32(logic signed [SAMPLE_BITS-1:0] v);
      return v[SAMPLE_BITS-1] ? SAMPLE_BITS'(-v) : SAMPLE_BITS'(v);
   endfunction
endpackage
`default_nettype wire

@@ hw/rtl/gitc_ram.sv @@
// Generic single-port RAM, read-first, registered read.
// Depends on nothing.
`default_nettype none
module gitc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     en,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         rdata <= mem[addr];
         if (we) begin
            mem[addr] <= wdata;
         end
      end
   end
endmodule
`default_nettype wire

@@ hw/rtl/gitc_edge.sv @@
// Edge unit: flatness test on a shared 32x32 multiplier, level bracket test,
// restoring divider for t, crossing point. Depends on gitc_pkg.
`default_nettype none
module gitc_edge (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire gitc_pkg::edge_req_type req,
   input  wire gitc_pkg::edge_cfg_type cfg,
   output logic                       pt_valid,
   input  wire logic                  pt_ready,
   output gitc_pkg::point_type        pt,
   output logic                       done
);
   import gitc_pkg::*;

   edge_state_type state_ff, state_in;
   edge_req_type   req_ff, req_in;
   logic [31:0] adz_ff, adz_in;
   logic [47:0] a_ff, a_in;
   logic [31:0] mz1_ff, mz1_in, mz2_ff, mz2_in, ee_ff, ee_in;
   logic [63:0] s_ff, s_in, prod_ff, prod_in;
   logic [95:0] lhs_ff, lhs_in, rhs_ff, rhs_in;
   logic [33:0] rem_ff, rem_in;
   logic [17:0] t_ff, t_in;
   logic [3:0]  step_ff, step_in;
   logic [4:0]  cnt_ff, cnt_in;

   logic signed [32:0] dz, numd;
   logic [32:0] adz_w, num_w;
   logic [47:0] lhs48, base48;
   logic signed [31:0] lo, hi;
   logic outside;
   logic [31:0] opa, opb;
   logic [3:0]  prev;
   logic ge;
   logic signed [27:0] xs, ys, yf;

   always_comb begin
      dz     = 33'(req_ff.qz) - 33'(req_ff.pz);
      adz_w  = dz[32] ? 33'(-dz) : 33'(dz);
      lhs48  = {adz_w[31:0], 16'd0};
      base48 = {16'd0, cfg.tol, 16'd0};
      lo     = (req_ff.pz < req_ff.qz) ? req_ff.pz : req_ff.qz;
      hi     = (req_ff.pz < req_ff.qz) ? req_ff.qz : req_ff.pz;
      outside = (cfg.level < lo) || (cfg.level > hi);
      numd   = 33'(cfg.level) - 33'(req_ff.pz);
      num_w  = numd[32] ? 33'(-numd) : 33'(numd);
      ge     = rem_ff >= {2'd0, adz_ff};
      prev   = step_ff - 4'd1;
      unique case (step_ff)
         4'd0: begin opa = {16'd0, cfg.tol}; opb = {16'd0, cfg.tol}; end
         4'd1: begin opa = mz1_ff; opb = mz1_ff; end
         4'd2: begin opa = mz2_ff; opb = mz2_ff; end
         4'd3: begin opa = {8'd0, a_ff[23:0]}; opb = {8'd0, a_ff[23:0]}; end
         4'd4: begin opa = {8'd0, a_ff[47:24]}; opb = {8'd0, a_ff[23:0]}; end
         4'd5: begin opa = {8'd0, a_ff[47:24]}; opb = {8'd0, a_ff[47:24]}; end
         4'd6: begin opa = ee_ff; opb = s_ff[31:0]; end
         4'd7: begin opa = ee_ff; opb = s_ff[63:32]; end
         default: begin opa = '0; opb = '0; end
      endcase
      // crossing point from p plus signed unit step times t
      xs = 28'({req_ff.px, 16'd0});
      if (req_ff.qx > req_ff.px) xs = xs + 28'(t_ff);
      else if (req_ff.qx < req_ff.px) xs = xs - 28'(t_ff);
      ys = 28'({req_ff.py, 16'd0});
      if (req_ff.qy > req_ff.py) ys = ys + 28'(t_ff);
      else if (req_ff.qy < req_ff.py) ys = ys - 28'(t_ff);
      yf = ys;
      if (!cfg.keep) begin
         yf = 28'({cfg.rows - 11'd1, 16'd0}) - ys;
         if (yf < 0) yf = '0;
      end
      if (xs < 0) xs = '0;
      pt.x = xs[25:0];
      pt.y = yf[25:0];
   end

   always_comb begin
      state_in = state_ff;
      req_in   = req_ff;
      adz_in   = adz_ff;
      a_in     = a_ff;
      mz1_in   = mz1_ff;
      mz2_in   = mz2_ff;
      ee_in    = ee_ff;
      s_in     = s_ff;
      prod_in  = prod_ff;
      lhs_in   = lhs_ff;
      rhs_in   = rhs_ff;
      rem_in   = rem_ff;
      t_in     = t_ff;
      step_in  = step_ff;
      cnt_in   = cnt_ff;
      done     = 1'b0;
      pt_valid = 1'b0;
      unique case (state_ff)
         E_IDLE: begin
            if (start) begin
               req_in   = req;
               state_in = E_PREP;
            end
         end
         E_PREP: begin
            if (dz == 0 || lhs48 < base48 || outside) begin
               done     = 1'b1;
               state_in = E_IDLE;
            end else begin
               adz_in   = adz_w[31:0];
               a_in     = lhs48 - base48;
               mz1_in   = mag32(req_ff.pz);
               mz2_in   = mag32(req_ff.qz);
               s_in     = '0;
               lhs_in   = '0;
               rhs_in   = '0;
               rem_in   = {1'b0, num_w};
               step_in  = '0;
               state_in = E_MUL;
            end
         end
         E_MUL: begin
            prod_in = opa * opb;
            if (step_ff != 4'd0) begin
               unique case (prev)
                  4'd0: ee_in = prod_ff[31:0];
                  4'd1, 4'd2: s_in = s_ff + prod_ff;
                  4'd3: lhs_in = lhs_ff + 96'(prod_ff);
                  4'd4: lhs_in = lhs_ff + (96'(prod_ff) << 25);
                  4'd5: lhs_in = lhs_ff + (96'(prod_ff) << 48);
                  4'd6: rhs_in = rhs_ff + 96'(prod_ff);
                  4'd7: rhs_in = rhs_ff + (96'(prod_ff) << 32);
                  default: ;
               endcase
            end
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd8) state_in = E_CMP;
         end
         E_CMP: begin
            if (lhs_ff < rhs_ff) begin
               done     = 1'b1;
               state_in = E_IDLE;
            end else begin
               t_in     = '0;
               cnt_in   = '0;
               state_in = E_DIV;
            end
         end
         E_DIV: begin
            t_in   = {t_ff[16:0], ge};
            rem_in = (ge ? rem_ff - {2'd0, adz_ff} : rem_ff) << 1;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(FRACTION_BITS)) state_in = E_ROUND;
         end
         E_ROUND: begin
            t_in     = t_ff + 18'(ge);
            state_in = E_OUT;
         end
         E_OUT: begin
            pt_valid = 1'b1;
            if (pt_ready) begin
               done     = 1'b1;
               state_in = E_IDLE;
            end
         end
         default: state_in = E_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
      end else begin
         state_ff <= state_in;
      end
      req_ff  <= req_in;
      adz_ff  <= adz_in;
      a_ff    <= a_in;
      mz1_ff  <= mz1_in;
      mz2_ff  <= mz2_in;
      ee_ff   <= ee_in;
      s_ff    <= s_in;
      prod_ff <= prod_in;
      lhs_ff  <= lhs_in;
      rhs_ff  <= rhs_in;
      rem_ff  <= rem_in;
      t_ff    <= t_in;
      step_ff <= step_in;
      cnt_ff  <= cnt_in;
   end
endmodule
`default_nettype wire

@@ hw/rtl/grid_isoline_triangle_crossings_core.sv @@
// Top level: line buffer, cell sequencer, result staging and register port.
// Depends on gitc_pkg, gitc_ram and gitc_edge.
//
// channel  dir   handshake            payload
// req      in    req_tvalid/tready    tdata sample, tuser frame_start
// rsp      out   rsp_tvalid/tready    tdata point x,y; tuser flags; tlast
// csr      in    psel/penable/pready  5 registers at byte address 4*i
//
// A sample that completes no cell passes the idle, read and flush steps. A
// sample that completes a cell walks every edge of both its triangles one
// after the other through the edge unit: a skipped edge ends at the prep or
// compare step, a crossing runs the multiplier and divider steps, rounding
// and output. Reset clears counters, edge samples and registers; the line
// buffer is not cleared. A stalled rsp holds the edge unit in its output step.
`default_nettype none
module grid_isoline_triangle_crossings_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] sample_value
   input  wire logic        req_tuser,   // [0] frame_start
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata,   // [25:0] point_x, [51:26] point_y, rest zero
   output logic [1:0]       rsp_tuser,   // [0] second_triangle, [1] new_triangle
   output logic             rsp_tlast,   // last_of_run
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import gitc_pkg::*;

   // ---- registers ----
   logic signed [31:0] level_ff;
   logic [15:0] tol_ff;
   logic keep_ff;
   logic [CNT_BITS-1:0] cols_ff, rows_ff;
   logic csr_wr;
   logic [CNT_BITS-1:0] cols_eff, rows_eff;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
         tol_ff   <= '0;
         keep_ff  <= 1'b0;
         cols_ff  <= 11'd2;
         rows_ff  <= 11'd2;
      end else if (csr_wr) begin
         unique case (csr_paddr[4:2])
            REG_LEVEL:   level_ff <= csr_pwdata;
            REG_TOL:     tol_ff   <= csr_pwdata[15:0];
            REG_KEEP:    keep_ff  <= csr_pwdata[0];
            REG_COLUMNS: cols_ff  <= csr_pwdata[10:0];
            REG_ROWS:    rows_ff  <= csr_pwdata[10:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[4:2])
         REG_LEVEL:   csr_prdata = level_ff;
         REG_TOL:     csr_prdata = {16'd0, tol_ff};
         REG_KEEP:    csr_prdata = {31'd0, keep_ff};
         REG_COLUMNS: csr_prdata = {21'd0, cols_ff};
         REG_ROWS:    csr_prdata = {21'd0, rows_ff};
         default:     csr_prdata = '0;
      endcase
      // clamp to [2, max]
      cols_eff = (cols_ff < 11'd2) ? 11'd2 :
                 (cols_ff > 11'(MAX_COLUMNS)) ? 11'(MAX_COLUMNS) : cols_ff;
      rows_eff = (rows_ff < 11'd2) ? 11'd2 :
                 (rows_ff > 11'(MAX_ROWS)) ? 11'(MAX_ROWS) : rows_ff;
   end

   // ---- sequencer state ----
   top_state_type state_ff, state_in;
   logic [COL_BITS-1:0] col_ff, col_in, row_ff, row_in;   // counters
   logic [COL_BITS-1:0] ccol_ff, ccol_in, crow_ff, crow_in; // current sample place
   logic signed [31:0] left_ff, left_in, ul_ff, ul_in, above_ff, above_in, z_ff, z_in;
   logic [2:0] idx_ff, idx_in;
   logic first_ff, first_in;
   logic req_acc;
   logic [CNT_BITS-1:0] c0, r0, c1, r1;
   logic [31:0] ram_rdata;

   // staging: pend holds the newest point until it is known whether it is last
   result_type pend_ff, pend_in, out_ff, out_in;
   logic pend_v_ff, pend_v_in, out_v_ff, out_v_in, out_last_ff, out_last_in;
   logic out_can;

   edge_req_type ereq;
   edge_cfg_type ecfg;
   point_type    ept;
   logic e_start, e_valid, e_ready, e_done;

   assign req_acc = req_tvalid && req_tready;
   assign out_can = !out_v_ff || rsp_tready;

   // counter wrap before use
   always_comb begin
      c0 = req_tuser ? '0 : 11'(col_ff);
      r0 = req_tuser ? '0 : 11'(row_ff);
      if (c0 >= cols_eff) begin
         c0 = '0;
         r0 = r0 + 11'd1;
      end
      if (r0 >= rows_eff) r0 = '0;
      // advance after use
      c1 = 11'(ccol_ff) + 11'd1;
      r1 = 11'(crow_ff);
      if (c1 >= cols_eff) begin
         c1 = '0;
         r1 = r1 + 11'd1;
         if (r1 >= rows_eff) r1 = '0;
      end
   end

   gitc_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_COLUMNS)) u_line (
      .clock (clock),
      .en    (req_acc),
      .we    (req_acc),
      .addr  (c0[COL_BITS-1:0]),
      .wdata (req_tdata),
      .rdata (ram_rdata)
   );

   // edge endpoints: A = v00,v01,v10 ; B = v11,v01,v10
   always_comb begin
      logic [COL_BITS-1:0] x0, y0;
      x0 = ccol_ff - 10'd1;
      y0 = crow_ff - 10'd1;
      ereq = '0;
      unique case (idx_ff)
         3'd0: begin
            ereq.pz = ul_ff;    ereq.px = x0;      ereq.py = y0;
            ereq.qz = left_ff;  ereq.qx = x0;      ereq.qy = crow_ff;
         end
         3'd1, 3'd4: begin
            ereq.pz = left_ff;  ereq.px = x0;      ereq.py = crow_ff;
            ereq.qz = above_ff; ereq.qx = ccol_ff; ereq.qy = y0;
         end
         3'd2: begin
            ereq.pz = above_ff; ereq.px = ccol_ff; ereq.py = y0;
            ereq.qz = ul_ff;    ereq.qx = x0;      ereq.qy = y0;
         end
         3'd3: begin
            ereq.pz = z_ff;     ereq.px = ccol_ff; ereq.py = crow_ff;
            ereq.qz = left_ff;  ereq.qx = x0;      ereq.qy = crow_ff;
         end
         3'd5: begin
            ereq.pz = above_ff; ereq.px = ccol_ff; ereq.py = y0;
            ereq.qz = z_ff;     ereq.qx = ccol_ff; ereq.qy = crow_ff;
         end
         default: ereq = '0;
      endcase
      ecfg.level = level_ff;
      ecfg.tol   = tol_ff;
      ecfg.keep  = keep_ff;
      ecfg.rows  = rows_eff;
   end

   gitc_edge u_edge (
      .clock    (clock),
      .reset    (reset),
      .start    (e_start),
      .req      (ereq),
      .cfg      (ecfg),
      .pt_valid (e_valid),
      .pt_ready (e_ready),
      .pt       (ept),
      .done     (e_done)
   );

   assign e_ready = !pend_v_ff || out_can;

   always_comb begin
      state_in    = state_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      ccol_in     = ccol_ff;
      crow_in     = crow_ff;
      left_in     = left_ff;
      ul_in       = ul_ff;
      above_in    = above_ff;
      z_in        = z_ff;
      idx_in      = idx_ff;
      first_in    = first_ff;
      pend_in     = pend_ff;
      pend_v_in   = pend_v_ff;
      out_in      = out_ff;
      out_v_in    = out_v_ff && !rsp_tready;
      out_last_in = out_last_ff;
      req_tready  = 1'b0;
      e_start     = 1'b0;

      // a new point pushes the pending one out as not last
      if (e_valid && e_ready) begin
         if (pend_v_ff) begin
            out_in      = pend_ff;
            out_v_in    = 1'b1;
            out_last_in = 1'b0;
         end
         pend_in.x     = ept.x;
         pend_in.y     = ept.y;
         pend_in.tri_b = (idx_ff >= 3'd3);
         pend_in.first = first_ff;
         pend_v_in     = 1'b1;
         first_in      = 1'b0;
      end

      unique case (state_ff)
         T_IDLE: begin
            req_tready = 1'b1;
            if (req_acc) begin
               ccol_in  = c0[COL_BITS-1:0];
               crow_in  = r0[COL_BITS-1:0];
               z_in     = req_tdata;
               state_in = T_READ;
            end
         end
         T_READ: begin
            above_in = ram_rdata;
            idx_in   = '0;
            if (ccol_ff != '0 && crow_ff != '0) state_in = T_START;
            else state_in = T_FLUSH;
         end
         T_START: begin
            e_start  = 1'b1;
            if (idx_ff == 3'd0 || idx_ff == 3'd3) first_in = 1'b1;
            state_in = T_WAIT;
         end
         T_WAIT: begin
            if (e_done) begin
               if (idx_ff == 3'd5) state_in = T_FLUSH;
               else begin
                  idx_in   = idx_ff + 3'd1;
                  state_in = T_START;
               end
            end
         end
         T_FLUSH: begin
            if (!pend_v_ff || out_can) begin
               if (pend_v_ff) begin
                  out_in      = pend_ff;
                  out_v_in    = 1'b1;
                  out_last_in = 1'b1;
                  pend_v_in   = 1'b0;
               end
               ul_in    = above_ff;
               left_in  = z_ff;
               col_in   = c1[COL_BITS-1:0];
               row_in   = r1[COL_BITS-1:0];
               state_in = T_IDLE;
            end
         end
         default: state_in = T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= T_IDLE;
         col_ff    <= '0;
         row_ff    <= '0;
         left_ff   <= '0;
         ul_ff     <= '0;
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
         idx_ff    <= '0;
         first_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         left_ff   <= left_in;
         ul_ff     <= ul_in;
         pend_v_ff <= pend_v_in;
         out_v_ff  <= out_v_in;
         idx_ff    <= idx_in;
         first_ff  <= first_in;
      end
      ccol_ff     <= ccol_in;
      crow_ff     <= crow_in;
      above_ff    <= above_in;
      z_ff        <= z_in;
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {4'd0, out_ff.y, out_ff.x};
   assign rsp_tuser  = {out_ff.first, out_ff.tri_b};
   assign rsp_tlast  = out_last_ff;

   // ---- checks ----
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !pend_v_ff)
      else $error("input taken while a point is still staged");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (e_valid && e_ready && pend_v_ff) |-> out_can)
      else $error("staged point pushed over a held output word");
   a_done_wait: assert property (@(posedge clock) disable iff (reset)
      e_done |-> (state_ff == T_WAIT))
      else $error("edge unit finished outside the wait step");
endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking bench for grid_isoline_triangle_crossings_core: streams height grids
// and checks every isoline crossing against an in-bench predictor of the core.
// Depends on gitc_pkg and the core RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
   import gitc_pkg::*;

   typedef struct {
      logic [31:0] sample;
      logic        frame_start;
   } sample_word_type;

   typedef struct {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic                  tri_b;
      logic                  first;
      logic                  last;
   } crossing_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [31:0] sample_value
   logic        req_tuser = 1'b0; // [0] frame_start
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;        // [25:0] point_x, [51:26] point_y
   logic [1:0]  rsp_tuser;        // [0] second_triangle, [1] new_triangle
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   grid_isoline_triangle_crossings_core i_dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   sample_word_type pending_samples[$];
   crossing_type    expected_crossings[$];
   int              error_count = 0;
   int              idle_mode = 0;   // 0: sender 19%/receiver 85%, 1: swapped, 2: none
   bit              hold_arm = 1'b0;

   // shadow of the register file
   logic signed [31:0] level_reg = '0;
   logic [15:0]        tol_reg = '0;
   logic               keep_reg = 1'b0;
   logic [10:0]        cols_reg = 11'd2;
   logic [10:0]        rows_reg = 11'd2;

   // shadow of the grid state
   logic signed [31:0] line_buf[MAX_COLUMNS];
   logic signed [31:0] left_z = '0;
   logic signed [31:0] upleft_z = '0;
   int                 col_idx = 0;
   int                 row_idx = 0;

   function automatic int clamp_count(logic [10:0] v, int hi);
      if (v < 2) return 2;
      if (v > hi) return hi;
      return int'(v);
   endfunction

   function automatic longint unsigned abs64(longint v);
      return v < 0 ? longint'(-v) : v;
   endfunction

   // one edge p->q; appends a crossing if the edge is steep and brackets the level
   function automatic void cross_edge(longint px, longint py, longint pz, longint qx,
                                      longint qy, longint qz, logic tri_b,
                                      ref bit first, ref crossing_type hits[$]);
      longint            dz, lo, hi, x, y;
      longint unsigned   adz, lhs, base, a, s, num, rem, t;
      logic [127:0]      lhs_sq, rhs;
      crossing_type      hit;
      dz = qz - pz;
      if (dz == 0) return;
      adz = abs64(dz);
      lhs = adz << EPS_BITS;
      base = longint'(tol_reg) << FRACTION_BITS;
      if (lhs < base) return;
      a = lhs - base;
      s = abs64(pz) * abs64(pz) + abs64(qz) * abs64(qz);
      lhs_sq = {64'd0, a} * {64'd0, a};
      rhs = {64'd0, longint'(tol_reg) * longint'(tol_reg)} * {64'd0, s};
      if (lhs_sq < rhs) return;
      lo = pz < qz ? pz : qz;
      hi = pz < qz ? qz : pz;
      if (level_reg < lo || level_reg > hi) return;
      num = abs64(longint'(level_reg) - pz);
      rem = num;
      t = 0;
      for (int i = 0; i <= FRACTION_BITS; i++) begin
         t = t << 1;
         if (rem >= adz) begin
            rem = rem - adz;
            t = t | 1;
         end
         rem = rem << 1;
      end
      if (rem >= adz) t = t + 1;
      x = px * 65536 + (qx - px) * longint'(t);
      y = py * 65536 + (qy - py) * longint'(t);
      if (!keep_reg) begin
         y = longint'(clamp_count(rows_reg, MAX_ROWS) - 1) * 65536 - y;
         if (y < 0) y = 0;
      end
      if (x < 0) x = 0;
      hit.x = x[COORD_BITS-1:0];
      hit.y = y[COORD_BITS-1:0];
      hit.tri_b = tri_b;
      hit.first = first;
      hit.last = 1'b0;
      first = 1'b0;
      hits.push_back(hit);
   endfunction

   // advances the grid shadow by one sample and queues the crossings it causes
   function automatic void predict_crossings(sample_word_type w);
      int                 cols, rows;
      longint             x0, y0, z00, z01, z10, z11;
      logic signed [31:0] above;
      crossing_type       hits[$];
      bit                 first;
      cols = clamp_count(cols_reg, MAX_COLUMNS);
      rows = clamp_count(rows_reg, MAX_ROWS);
      if (w.frame_start) begin
         col_idx = 0;
         row_idx = 0;
      end
      if (col_idx >= cols) begin
         col_idx = 0;
         row_idx++;
      end
      if (row_idx >= rows) row_idx = 0;
      above = line_buf[col_idx];
      if (row_idx >= 1 && col_idx >= 1) begin
         x0 = col_idx - 1;
         y0 = row_idx - 1;
         z00 = upleft_z;
         z01 = left_z;
         z10 = above;
         z11 = $signed(w.sample);
         first = 1'b1;
         cross_edge(x0, y0, z00, x0, y0 + 1, z01, 1'b0, first, hits);
         cross_edge(x0, y0 + 1, z01, x0 + 1, y0, z10, 1'b0, first, hits);
         cross_edge(x0 + 1, y0, z10, x0, y0, z00, 1'b0, first, hits);
         first = 1'b1;
         cross_edge(x0 + 1, y0 + 1, z11, x0, y0 + 1, z01, 1'b1, first, hits);
         cross_edge(x0, y0 + 1, z01, x0 + 1, y0, z10, 1'b1, first, hits);
         cross_edge(x0 + 1, y0, z10, x0 + 1, y0 + 1, z11, 1'b1, first, hits);
      end
      upleft_z = above;
      line_buf[col_idx] = w.sample;
      left_z = w.sample;
      col_idx++;
      if (col_idx >= cols) begin
         col_idx = 0;
         row_idx++;
         if (row_idx >= rows) row_idx = 0;
      end
      if (hits.size() > 0) hits[hits.size() - 1].last = 1'b1;
      foreach (hits[i]) expected_crossings.push_back(hits[i]);
   endfunction

   // sample driver; prediction happens on the accepting edge
   always @(posedge clock) begin
      sample_word_type w;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) predict_crossings('{req_tdata, req_tuser});
         if (!req_tvalid || req_tready) begin
            if (pending_samples.size() > 0 &&
                $urandom_range(99) >= (idle_mode == 0 ? 19 : idle_mode == 1 ? 85 : 0)) begin
               w = pending_samples.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= w.sample;
               req_tuser <= w.frame_start;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // crossing monitor and receiver back-pressure
   int  hold_left = 0;
   bit  hold_used = 1'b0;
   always @(posedge clock) begin
      crossing_type exp_c;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_crossings.size() == 0) begin
               $error("unexpected crossing x=%0d y=%0d", rsp_tdata[25:0], rsp_tdata[51:26]);
               error_count++;
            end else begin
               exp_c = expected_crossings.pop_front();
               if (rsp_tdata[25:0] !== exp_c.x) begin
                  $error("point_x exp %0d got %0d", exp_c.x, rsp_tdata[25:0]);
                  error_count++;
               end
               if (rsp_tdata[51:26] !== exp_c.y) begin
                  $error("point_y exp %0d got %0d", exp_c.y, rsp_tdata[51:26]);
                  error_count++;
               end
               if (rsp_tuser[0] !== exp_c.tri_b) begin
                  $error("second_triangle exp %0d got %0d", exp_c.tri_b, rsp_tuser[0]);
                  error_count++;
               end
               if (rsp_tuser[1] !== exp_c.first) begin
                  $error("new_triangle exp %0d got %0d", exp_c.first, rsp_tuser[1]);
                  error_count++;
               end
               if (rsp_tlast !== exp_c.last) begin
                  $error("last_of_run exp %0d got %0d", exp_c.last, rsp_tlast);
                  error_count++;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (hold_arm && !hold_used) begin
            // long stall so the core fills up and pushes back on req
            hold_used <= 1'b1;
            hold_left <= 1500;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= $urandom_range(99) >= (idle_mode == 0 ? 85 : idle_mode == 1 ? 19 : 0);
         end
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_LEVEL:   level_reg = value;
         REG_TOL:     tol_reg = value[15:0];
         REG_KEEP:    keep_reg = value[0];
         REG_COLUMNS: cols_reg = value[10:0];
         REG_ROWS:    rows_reg = value[10:0];
         default: ;
      endcase
   endtask

   task automatic load_grid_setup(logic [31:0] lvl, logic [15:0] tol, logic keep,
                                  logic [10:0] cols, logic [10:0] rows);
      csr_write(REG_LEVEL, lvl);
      csr_write(REG_TOL, {16'd0, tol});
      csr_write(REG_KEEP, {31'd0, keep});
      csr_write(REG_COLUMNS, {21'd0, cols});
      csr_write(REG_ROWS, {21'd0, rows});
   endtask

   // wait for the queue, the core and the expectations to drain
   task automatic drain_grid();
      while (pending_samples.size() > 0 || req_tvalid || expected_crossings.size() > 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_sample(logic [31:0] lvl);
      case ($urandom_range(7))
         0: return $urandom;
         1: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
         2: return lvl;
         3: return lvl + ($urandom_range(1) ? 32'($urandom_range(255)) : -32'($urandom_range(255)));
         default: return lvl + 32'($signed($urandom_range(1 << 21)) - (1 << 20));
      endcase
   endfunction

   task automatic add_grid(logic [31:0] lvl, int count, bit with_start);
      for (int i = 0; i < count; i++)
         pending_samples.push_back('{pick_sample(lvl), with_start && i == 0});
   endtask

   initial begin
      logic [31:0] lvl;
      logic [10:0] cols;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: 3x3 grid, extremes, flat edges, level on a vertex
      load_grid_setup(32'h0000_8000, 16'd0, 1'b0, 11'd3, 11'd3);
      csr_write(3'd5, 32'hffff_ffff);   // unmapped, ignored
      csr_write(3'd7, 32'h0);
      pending_samples.push_back('{32'h0000_0000, 1'b1});
      pending_samples.push_back('{32'h0001_0000, 1'b0});
      pending_samples.push_back('{32'h7fff_ffff, 1'b0});
      pending_samples.push_back('{32'h8000_0000, 1'b0});
      pending_samples.push_back('{32'h0000_8000, 1'b0});
      pending_samples.push_back('{32'h0000_8000, 1'b0});
      pending_samples.push_back('{32'h0000_8000, 1'b0});
      pending_samples.push_back('{32'h0000_8000, 1'b0});
      pending_samples.push_back('{32'hffff_0000, 1'b0});
      pending_samples.push_back('{32'h0000_8001, 1'b1});
      pending_samples.push_back('{32'h0000_7fff, 1'b0});
      pending_samples.push_back('{32'h0000_8000, 1'b0});
      pending_samples.push_back('{32'h8000_0000, 1'b0});
      pending_samples.push_back('{32'h7fff_ffff, 1'b0});
      pending_samples.push_back('{32'h0000_8000, 1'b0});
      drain_grid();
      // same level, widest tolerance, kept orientation, grids that wrap by themselves
      load_grid_setup(32'h0000_8000, 16'hffff, 1'b1, 11'd0, 11'd2047);
      pending_samples.push_back('{32'h0000_0000, 1'b1});
      pending_samples.push_back('{32'h7fff_ffff, 1'b0});
      pending_samples.push_back('{32'h8000_0000, 1'b0});
      pending_samples.push_back('{32'h0000_ffff, 1'b0});
      drain_grid();

      // random grids of small sizes
      for (int ph = 0; ph < 12; ph++) begin
         idle_mode = ph < 4 ? 0 : ph < 8 ? 1 : 2;
         case ($urandom_range(3))
            0: lvl = $urandom;
            1: lvl = $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: lvl = 32'($signed($urandom_range(1 << 20)) - (1 << 19));
         endcase
         cols = 11'($urandom_range(2, 7));
         load_grid_setup(lvl, $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(63)),
                         1'($urandom), cols, 11'($urandom_range(2, 6)));
         if (ph == 9) hold_arm = 1'b1;
         add_grid(lvl, ph == 9 ? 40 : 12, 1'b1);
         drain_grid();
         // shrink columns mid-frame: counters wrap without a frame start
         if (ph == 5) begin
            csr_write(REG_COLUMNS, 32'd2);
            add_grid(lvl, 10, 1'b0);
            drain_grid();
         end
      end

      // oversized column count clamps to the widest row
      idle_mode = 2;
      load_grid_setup(32'h0000_0000, 16'd0, 1'b0, 11'd2047, 11'd1024);
      for (int i = 0; i < 24; i++)
         pending_samples.push_back('{i[0] ? 32'h0001_0000 : 32'hffff_0000, i == 0});
      drain_grid();

      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #50ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
`default_nettype wire
